>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/psch_pkg.sv
// ----------------------------------------------------------------------------
// psch_pkg
// shared widths, codes and types of the priority scheduler
// ----------------------------------------------------------------------------
package psch_pkg;

  localparam int IDX_W       = 4;
  localparam int MAX_ENTRIES = 2 ** IDX_W;
  localparam int ARR_W       = 16;
  localparam int BUR_W       = 16;
  localparam int PRI_W       = 8;
  localparam int TIME_W      = 20;
  localparam int CNT_W       = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic capture;
    logic load;
    logic eval;
    logic pick;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  running_id;
    logic              idle;
    logic [TIME_W-1:0] slice_end;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
    logic              all_done;
    logic              load_error;
  } out_item_t;

endpackage

>>> sv/psch_if.sv
// ----------------------------------------------------------------------------
// psch_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface psch_in_if import psch_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [IDX_W-1:0]  proc_index;
  logic [ARR_W-1:0]  arrival;
  logic [BUR_W-1:0]  burst;
  logic [PRI_W-1:0]  prio;

  modport source (output valid, mode, proc_index, arrival, burst, prio, input ready);
  modport sink   (input valid, mode, proc_index, arrival, burst, prio, output ready);
endinterface

interface psch_out_if import psch_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  running_id;
  logic              idle;
  logic [TIME_W-1:0] slice_end;
  logic              finished;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [TIME_W-1:0] response;
  logic              all_done;
  logic              load_error;

  modport source (output valid, running_id, idle, slice_end, finished, completion_time,
                  turnaround, waiting, response, all_done, load_error, input ready);
  modport sink   (input valid, running_id, idle, slice_end, finished, completion_time,
                  turnaround, waiting, response, all_done, load_error, output ready);
endinterface

>>> sv/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: one-unit-per-tick priority scheduler
// tick item: capture, eval, priority tree pick, execute, then emit of the result beat
// load item: capture, table write, then emit of the result beat
// next item taken once its result beat is emitted
// two-stage registered priority tree over the process entries
// synchronous active-low reset: time 0, no service left, process_count 1
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler import psch_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  psch_in_if.sink           in_ch,
  psch_out_if.source        out_ch
);

  cmd_t      cmd;
  out_item_t res;
  logic      in_ready_w;
  logic      out_valid_w;

  psch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ready_w),
    .out_valid (out_valid_w),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  psch_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_mode       (in_ch.mode),
    .in_proc_index (in_ch.proc_index),
    .in_arrival    (in_ch.arrival),
    .in_burst      (in_ch.burst),
    .in_prio       (in_ch.prio),
    .res           (res)
  );

  assign in_ch.ready            = in_ready_w;
  assign out_ch.valid           = out_valid_w;
  assign out_ch.running_id      = res.running_id;
  assign out_ch.idle            = res.idle;
  assign out_ch.slice_end       = res.slice_end;
  assign out_ch.finished        = res.finished;
  assign out_ch.completion_time = res.completion_time;
  assign out_ch.turnaround      = res.turnaround;
  assign out_ch.waiting         = res.waiting;
  assign out_ch.response        = res.response;
  assign out_ch.all_done        = res.all_done;
  assign out_ch.load_error      = res.load_error;

  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMP(a_idle_no_run, clk, rst_n, out_ch.valid && out_ch.idle,
              (out_ch.running_id == '0) && !out_ch.finished)
  `ASSERT_IMP(a_finish_times, clk, rst_n, out_ch.valid && out_ch.finished,
              (out_ch.completion_time == out_ch.slice_end) &&
              (out_ch.turnaround >= out_ch.waiting))
  `ASSERT_IMP(a_err_on_load, clk, rst_n, out_ch.valid && out_ch.load_error,
              !out_ch.finished && !out_ch.idle)

endmodule

>>> sv/psch_ctrl.sv
// ----------------------------------------------------------------------------
// psch_ctrl
// sequencer: capture, table write or eval/pick/execute, then result beat
// ----------------------------------------------------------------------------
module psch_ctrl import psch_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_mode == MODE_TICK) ? S_EVAL : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_RESP;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/psch_dp.sv
// ----------------------------------------------------------------------------
// psch_dp
// process tables, two-stage priority tree, time and metric arithmetic
// ----------------------------------------------------------------------------
module psch_dp import psch_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_mode,
  input  logic [IDX_W-1:0]  in_proc_index,
  input  logic [ARR_W-1:0]  in_arrival,
  input  logic [BUR_W-1:0]  in_burst,
  input  logic [PRI_W-1:0]  in_prio,
  output out_item_t         res
);

  localparam int NE    = (MAX_PROCS < MAX_ENTRIES) ? MAX_PROCS : MAX_ENTRIES;
  localparam int IW    = $clog2(NE);
  localparam int KEY_W = 1 + PRI_W + IDX_W;
  localparam int GRP   = 4;
  localparam int NGRP  = MAX_ENTRIES / GRP;
  localparam logic [CNT_W-1:0] NE_V = CNT_W'(NE);

  typedef logic [KEY_W-1:0] key_t;

  function automatic key_t kmax(input key_t a, input key_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [TIME_W-1:0] sub_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // captured item
  logic              mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ARR_W-1:0]  arr_in_r;
  logic [BUR_W-1:0]  bur_in_r;
  logic [PRI_W-1:0]  pri_in_r;

  // process tables
  logic [ARR_W-1:0]  arr_tab_r [NE];
  logic [BUR_W-1:0]  bur_tab_r [NE];
  logic [BUR_W-1:0]  rem_tab_r [NE];
  logic [PRI_W-1:0]  pri_tab_r [NE];
  logic [TIME_W-1:0] fs_tab_r  [NE];
  logic [NE-1:0]     started_r;

  logic [CNT_W-1:0]  pc_r;
  logic [TIME_W-1:0] time_r;

  // pick pipeline
  key_t              key_w  [MAX_ENTRIES];
  key_t              grp_r  [NGRP];
  key_t              grp_nxt[NGRP];
  key_t              best_r;
  key_t              best_nxt;
  logic [TIME_W-1:0] end_r;
  logic [NE-1:0]     busy_w;

  // execute results
  logic [IDX_W-1:0]  pick_r;
  logic              idle_r;
  logic              fin_r;
  logic [TIME_W-1:0] tat_r;
  logic [TIME_W-1:0] resp_r;
  logic [BUR_W-1:0]  bsel_r;

  out_item_t         res_r, res_nxt;

  for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_key
    if (e < NE) begin : g_live
      logic live;
      logic elig;
      assign live       = (CNT_W'(e) < pc_r) && (rem_tab_r[e] != '0);
      assign elig       = live && ({{(TIME_W-ARR_W){1'b0}}, arr_tab_r[e]} <= time_r);
      assign busy_w[e]  = live;
      assign key_w[e]   = {elig, pri_tab_r[e], IDX_W'(e)};
    end else begin : g_pad
      assign key_w[e] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = kmax(kmax(key_w[GRP*g], key_w[GRP*g+1]),
                        kmax(key_w[GRP*g+2], key_w[GRP*g+3]));
    end
    best_nxt = grp_r[0];
    for (int g = 1; g < NGRP; g++) begin
      best_nxt = kmax(best_nxt, grp_r[g]);
    end
  end

  // selected entry
  logic              sel_ok;
  logic [IW-1:0]     sel_i;
  logic [ARR_W-1:0]  sel_arr;
  logic [BUR_W-1:0]  sel_rem;
  logic [TIME_W-1:0] sel_fs;
  logic [TIME_W-1:0] sel_arr_x;

  assign sel_ok    = best_r[KEY_W-1];
  assign sel_i     = best_r[IW-1:0];
  assign sel_arr   = arr_tab_r[sel_i];
  assign sel_rem   = rem_tab_r[sel_i];
  assign sel_fs    = started_r[sel_i] ? fs_tab_r[sel_i] : time_r;
  assign sel_arr_x = {{(TIME_W-ARR_W){1'b0}}, sel_arr};

  logic load_wr;
  assign load_wr = cmd.load && (bur_in_r != '0) && ({1'b0, idx_r} < NE_V);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= CNT_W'(1);
      time_r    <= '0;
      started_r <= '0;
      for (int e = 0; e < NE; e++) begin
        rem_tab_r[e] <= '0;
      end
    end else begin
      if (cfg_we) begin
        pc_r <= cfg_data;
      end
      if (load_wr) begin
        rem_tab_r[idx_r[IW-1:0]] <= bur_in_r;
        started_r[idx_r[IW-1:0]] <= 1'b0;
      end
      if (cmd.exec) begin
        time_r <= end_r;
        if (sel_ok) begin
          rem_tab_r[sel_i] <= sel_rem - BUR_W'(1);
          started_r[sel_i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      idx_r    <= in_proc_index;
      arr_in_r <= in_arrival;
      bur_in_r <= in_burst;
      pri_in_r <= in_prio;
    end
    if (load_wr) begin
      arr_tab_r[idx_r[IW-1:0]] <= arr_in_r;
      bur_tab_r[idx_r[IW-1:0]] <= bur_in_r;
      pri_tab_r[idx_r[IW-1:0]] <= pri_in_r;
    end
    if (cmd.eval) begin
      grp_r <= grp_nxt;
    end
    if (cmd.pick) begin
      best_r <= best_nxt;
      end_r  <= (time_r == TIME_MAX) ? time_r : time_r + TIME_W'(1);
    end
    if (cmd.exec) begin
      idle_r <= !sel_ok;
      pick_r <= sel_ok ? best_r[IDX_W-1:0] : '0;
      fin_r  <= sel_ok && (sel_rem == BUR_W'(1));
      tat_r  <= sub_sat(end_r, sel_arr_x);
      resp_r <= sub_sat(sel_fs, sel_arr_x);
      bsel_r <= bur_tab_r[sel_i];
      if (sel_ok && !started_r[sel_i]) begin
        fs_tab_r[sel_i] <= time_r;
      end
    end
    if (cmd.emit) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    res_nxt            = '0;
    res_nxt.slice_end  = time_r;
    res_nxt.all_done   = ~|busy_w;
    if (mode_r == MODE_TICK) begin
      res_nxt.running_id = pick_r;
      res_nxt.idle       = idle_r;
      res_nxt.finished   = fin_r;
      if (fin_r) begin
        res_nxt.completion_time = time_r;
        res_nxt.turnaround      = tat_r;
        res_nxt.waiting         = sub_sat(tat_r, {{(TIME_W-BUR_W){1'b0}}, bsel_r});
        res_nxt.response        = resp_r;
      end
    end else begin
      res_nxt.load_error = (bur_in_r == '0);
    end
  end

  assign res = res_r;

endmodule
